// ----- sv/msc_pkg.sv -----
// package for the merge sort block: constants, phase codes, counter helper
`timescale 1ns / 1ps
package msc_pkg;

    localparam int MSC_MAX_ITEMS   = 64;
    localparam int MSC_VALUE_WIDTH = 32;
    localparam int COUNT_W         = 10;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // progress of one range of the split tree on the walk stack
    typedef enum logic [1:0] {
        PH_LEFT  = 2'd0,
        PH_RIGHT = 2'd1,
        PH_MERGE = 2'd2
    } phase_t;

    // saturating count step
    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] cnt);
        logic [COUNT_W-1:0] res;
        begin
            res = (cnt == COUNT_MAX) ? cnt : cnt + 1'b1;
            return res;
        end
    endfunction

endpackage

// ----- sv/msc_if.sv -----
// valid/ready channel interfaces for the input and result words
`timescale 1ns / 1ps
interface msc_in_if #(parameter int VALUE_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          final_item;

    modport source (output valid, output value, output final_item, input ready);
    modport sink (input valid, input value, input final_item, output ready);
endinterface

interface msc_out_if #(parameter int VALUE_WIDTH = 32, parameter int COUNT_W = 10);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] sorted_value;
    logic                          run_end;
    logic [COUNT_W-1:0]            compare_count;
    logic [COUNT_W-1:0]            move_count;
    logic                          overflowed;

    modport source (output valid, output sorted_value, output run_end,
                    output compare_count, output move_count, output overflowed,
                    input ready);
    modport sink (input valid, input sorted_value, input run_end,
                  input compare_count, input move_count, input overflowed,
                  output ready);
endinterface

// ----- sv/msc_ram.sv -----
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module msc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/merge_sort_with_counts.sv -----
// top level: word collection, top-down merge sort over rams, sorted run output
`timescale 1ns / 1ps
// Collects signed words one per cycle until a word with final_item set, then
// sorts them ascending with a stable top-down merge sort (split at
// lo + (hi-lo)/2, left side wins ties) and sends them out in order, run_end on
// the last. Words beyond MAX_ITEMS are dropped and reported through overflowed.
// Every result carries the comparison and assignment totals of the sort. The
// input is ready only while collecting. The element store is a single-port
// read ram and the merge sources come from two scratch copies, so a merge
// first copies its range out (S_CRD read, S_CWR write to both copies) and
// then merges it back (S_MRD read, S_MWR write). The split tree walk steps
// through each range in S_WALK. Each result word is read in S_ERD and held
// in S_EOUT until the output side takes it.
module merge_sort_with_counts
    import msc_pkg::*;
#(
    parameter int MAX_ITEMS   = MSC_MAX_ITEMS,
    parameter int VALUE_WIDTH = MSC_VALUE_WIDTH
) (
    input  logic      clk,
    input  logic      rst_n,
    msc_in_if.sink    items,
    msc_out_if.source results
);

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int STK_D = IDX_W + 1;
    localparam int SP_W  = (STK_D > 1) ? $clog2(STK_D) : 1;

    typedef enum logic [7:0] {
        S_LOAD = 8'b0000_0001,
        S_WALK = 8'b0000_0010,
        S_CRD  = 8'b0000_0100,
        S_CWR  = 8'b0000_1000,
        S_MRD  = 8'b0001_0000,
        S_MWR  = 8'b0010_0000,
        S_ERD  = 8'b0100_0000,
        S_EOUT = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0]   load_cnt_reg, load_cnt_next;
    logic               ovf_reg, ovf_next;
    logic [COUNT_W-1:0] cmp_reg, cmp_next;
    logic [COUNT_W-1:0] mov_reg, mov_next;
    logic [SP_W-1:0]    sp_reg, sp_next;
    logic [CNT_W-1:0]   a_reg, a_next;
    logic [CNT_W-1:0]   b_reg, b_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_end_reg, out_end_next;
    logic [VALUE_WIDTH-1:0] out_value_reg, out_value_next;

    // walk stack of split-tree ranges
    logic [IDX_W-1:0] stk_lo_reg [STK_D];
    logic [IDX_W-1:0] stk_hi_reg [STK_D];
    phase_t           stk_ph_reg [STK_D];

    logic             push;
    logic [SP_W-1:0]  push_idx;
    logic [IDX_W-1:0] push_lo;
    logic [IDX_W-1:0] push_hi;
    logic             ph_we;
    phase_t           ph_val;
    logic             pop;

    logic [IDX_W-1:0] top_lo, top_hi, top_mid;
    phase_t           top_ph;

    // memory ports
    logic                   e_we;
    logic [IDX_W-1:0]       e_waddr, e_raddr;
    logic [VALUE_WIDTH-1:0] e_wdata, e_rdata;
    logic                   s_we;
    logic [IDX_W-1:0]       s_waddr, s_raddr_a, s_raddr_b;
    logic [VALUE_WIDTH-1:0] s_wdata, sa_rdata, sb_rdata;

    logic [CNT_W-1:0] load_n;
    logic             a_ok, b_ok, take_a;

    assign top_lo  = stk_lo_reg[sp_reg];
    assign top_hi  = stk_hi_reg[sp_reg];
    assign top_ph  = stk_ph_reg[sp_reg];
    assign top_mid = top_lo + ((top_hi - top_lo) >> 1);

    assign load_n = (load_cnt_reg < CNT_W'(MAX_ITEMS)) ? load_cnt_reg + 1'b1 : load_cnt_reg;

    assign a_ok   = (a_reg <= CNT_W'(top_mid));
    assign b_ok   = (b_reg <= CNT_W'(top_hi));
    assign take_a = a_ok && (!b_ok || ($signed(sa_rdata) <= $signed(sb_rdata)));

    msc_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_ITEMS)) u_elem_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    // two scratch copies written together, one per merge side
    msc_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_ITEMS)) u_scr_a_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr_a),
        .rdata (sa_rdata)
    );

    msc_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_ITEMS)) u_scr_b_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr_b),
        .rdata (sb_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        load_cnt_next  = load_cnt_reg;
        ovf_next       = ovf_reg;
        cmp_next       = cmp_reg;
        mov_next       = mov_reg;
        sp_next        = sp_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        out_end_next   = out_end_reg;
        out_value_next = out_value_reg;

        push     = 1'b0;
        push_idx = SP_W'(sp_reg + 1'b1);
        push_lo  = top_lo;
        push_hi  = top_hi;
        ph_we    = 1'b0;
        ph_val   = PH_LEFT;
        pop      = 1'b0;

        e_we      = 1'b0;
        e_waddr   = k_reg[IDX_W-1:0];
        e_wdata   = take_a ? sa_rdata : sb_rdata;
        e_raddr   = k_reg[IDX_W-1:0];
        s_we      = 1'b0;
        s_waddr   = k_reg[IDX_W-1:0];
        s_wdata   = e_rdata;
        s_raddr_a = a_reg[IDX_W-1:0];
        s_raddr_b = b_reg[IDX_W-1:0];

        unique case (state_reg)
            S_LOAD:
            begin
                if (items.valid)
                begin
                    if (load_cnt_reg < CNT_W'(MAX_ITEMS))
                    begin
                        e_we          = 1'b1;
                        e_waddr       = load_cnt_reg[IDX_W-1:0];
                        e_wdata       = items.value;
                        load_cnt_next = load_n;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (items.final_item)
                    begin
                        // root range covers the whole batch
                        push       = 1'b1;
                        push_idx   = '0;
                        push_lo    = '0;
                        push_hi    = IDX_W'(load_n - 1'b1);
                        sp_next    = '0;
                        cmp_next   = '0;
                        mov_next   = '0;
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                unique case (top_ph)
                    PH_LEFT:
                    begin
                        if (top_lo >= top_hi)
                        begin
                            pop = 1'b1;
                        end
                        else
                        begin
                            ph_we   = 1'b1;
                            ph_val  = PH_RIGHT;
                            push    = 1'b1;
                            push_hi = top_mid;
                            sp_next = push_idx;
                        end
                    end
                    PH_RIGHT:
                    begin
                        ph_we   = 1'b1;
                        ph_val  = PH_MERGE;
                        push    = 1'b1;
                        push_lo = top_mid + 1'b1;
                        sp_next = push_idx;
                    end
                    PH_MERGE:
                    begin
                        k_next     = CNT_W'(top_lo);
                        state_next = S_CRD;
                    end
                    default:
                    begin
                        pop = 1'b1;
                    end
                endcase
            end
            S_CRD:
            begin
                state_next = S_CWR;
            end
            S_CWR:
            begin
                s_we     = 1'b1;
                mov_next = sat_inc(mov_reg);
                if (k_reg == CNT_W'(top_hi))
                begin
                    a_next     = CNT_W'(top_lo);
                    b_next     = CNT_W'(top_mid) + 1'b1;
                    k_next     = CNT_W'(top_lo);
                    state_next = S_MRD;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_CRD;
                end
            end
            S_MRD:
            begin
                state_next = S_MWR;
            end
            S_MWR:
            begin
                e_we     = 1'b1;
                mov_next = sat_inc(mov_reg);
                if (a_ok && b_ok)
                begin
                    cmp_next = sat_inc(cmp_reg);
                end
                if (take_a)
                begin
                    a_next = a_reg + 1'b1;
                end
                else
                begin
                    b_next = b_reg + 1'b1;
                end
                if (k_reg == CNT_W'(top_hi))
                begin
                    pop = 1'b1;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_MRD;
                end
            end
            S_ERD:
            begin
                // ram data lands next cycle, captured on the way into S_EOUT
                state_next = S_EOUT;
            end
            S_EOUT:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = e_rdata;
                    out_end_next   = (k_reg == load_cnt_reg - 1'b1);
                end
                else if (results.ready)
                begin
                    out_valid_next = 1'b0;
                    if (out_end_reg)
                    begin
                        load_cnt_next = '0;
                        ovf_next      = 1'b0;
                        state_next    = S_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_ERD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase

        if (pop)
        begin
            if (sp_reg == '0)
            begin
                k_next     = '0;
                state_next = S_ERD;
            end
            else
            begin
                sp_next    = sp_reg - 1'b1;
                state_next = S_WALK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            load_cnt_reg  <= '0;
            ovf_reg       <= 1'b0;
            cmp_reg       <= '0;
            mov_reg       <= '0;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            load_cnt_reg  <= load_cnt_next;
            ovf_reg       <= ovf_next;
            cmp_reg       <= cmp_next;
            mov_reg       <= mov_next;
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg         <= a_next;
        b_reg         <= b_next;
        k_reg         <= k_next;
        out_end_reg   <= out_end_next;
        out_value_reg <= out_value_next;
        if (ph_we)
        begin
            stk_ph_reg[sp_reg] <= ph_val;
        end
        if (push)
        begin
            stk_lo_reg[push_idx] <= push_lo;
            stk_hi_reg[push_idx] <= push_hi;
            stk_ph_reg[push_idx] <= PH_LEFT;
        end
    end

    assign items.ready           = (state_reg == S_LOAD);
    assign results.valid         = out_valid_reg;
    assign results.sorted_value  = out_value_reg;
    assign results.run_end       = out_end_reg;
    assign results.compare_count = cmp_reg;
    assign results.move_count    = mov_reg;
    assign results.overflowed    = ovf_reg;

`ifndef SYNTHESIS
    // collecting and sending never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(items.ready && results.valid))
        else $error("input ready while a result word is pending");

    // walk stack stays within the split tree depth
    a_stack_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (sp_reg <= SP_W'(STK_D - 1)))
        else $error("walk stack pointer beyond tree depth");

    // a merge write never runs past the end of its range
    a_merge_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MWR) |-> (k_reg <= CNT_W'(top_hi)))
        else $error("merge write beyond range end");

    // every merge write takes exactly one side
    a_merge_side: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MWR) |=> ((a_reg + b_reg) == ($past(a_reg) + $past(b_reg) + 1'b1)))
        else $error("merge step did not advance exactly one side");

    // the run ends by returning to collection with the load count and overflow flag cleared
    a_run_close: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.ready && results.run_end) |=>
        (items.ready && (load_cnt_reg == '0) && !ovf_reg))
        else $error("run end did not return to collection");
`endif

endmodule

// ----- tb/sv/merge_sort_with_counts_tb.sv -----
// testbench for merge_sort_with_counts: directed and random batches checked against a sorting predictor
`timescale 1ns / 1ps
module merge_sort_with_counts_tb
    import msc_pkg::*;
;

    typedef struct {
        bit signed [MSC_VALUE_WIDTH-1:0] value;
        bit                              final_item;
        bit                              hold_for_drain;
    } input_word_t;

    typedef struct {
        bit signed [MSC_VALUE_WIDTH-1:0] sorted_value;
        bit                              run_end;
        bit [COUNT_W-1:0]                compare_count;
        bit [COUNT_W-1:0]                move_count;
        bit                              overflowed;
    } sorted_word_t;

    logic clk;
    logic rst_n;

    msc_in_if  #(.VALUE_WIDTH(MSC_VALUE_WIDTH)) items ();
    msc_out_if #(.VALUE_WIDTH(MSC_VALUE_WIDTH), .COUNT_W(COUNT_W)) results ();

    merge_sort_with_counts #(
        .MAX_ITEMS   (MSC_MAX_ITEMS),
        .VALUE_WIDTH (MSC_VALUE_WIDTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results)
    );

    input_word_t  pending_words[$];
    sorted_word_t sorted_expect[$];

    // batch being collected by the predictor
    bit signed [MSC_VALUE_WIDTH-1:0] batch_words [MSC_MAX_ITEMS];
    bit signed [MSC_VALUE_WIDTH-1:0] merge_tmp [MSC_MAX_ITEMS];
    int unsigned batch_len;
    bit          batch_overflow;
    int unsigned compare_total;
    int unsigned move_total;

    int unsigned words_queued;
    int unsigned words_accepted;
    int unsigned results_seen;
    int unsigned fail_count;
    bit          word_taken;

    int unsigned gap_left;
    int unsigned burst_left;
    int unsigned stall_left;
    bit          long_hold_done;
    bit [7:0]    stall_pattern;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic void bump_compare();
        if (compare_total < COUNT_MAX)
            compare_total++;
    endfunction

    function automatic void bump_move();
        if (move_total < COUNT_MAX)
            move_total++;
    endfunction

    function automatic void merge_span(input int lo, input int mid, input int hi);
        int a;
        int b;
        int k;
        for (k = lo; k <= hi; k++)
        begin
            merge_tmp[k] = batch_words[k];
            bump_move();
        end
        a = lo;
        b = mid + 1;
        k = lo;
        // left side wins ties, which keeps the sort stable
        while (a <= mid && b <= hi)
        begin
            bump_compare();
            if (merge_tmp[a] <= merge_tmp[b])
                batch_words[k++] = merge_tmp[a++];
            else
                batch_words[k++] = merge_tmp[b++];
            bump_move();
        end
        while (a <= mid)
        begin
            batch_words[k++] = merge_tmp[a++];
            bump_move();
        end
        while (b <= hi)
        begin
            batch_words[k++] = merge_tmp[b++];
            bump_move();
        end
    endfunction

    function automatic void sort_span(input int lo, input int hi);
        int mid;
        if (lo >= hi)
            return;
        mid = lo + (hi - lo) / 2;
        sort_span(lo, mid);
        sort_span(mid + 1, hi);
        merge_span(lo, mid, hi);
    endfunction

    function automatic void predict_sorted_run();
        sorted_word_t exp_word;
        compare_total = 0;
        move_total = 0;
        if (batch_len > 0)
            sort_span(0, batch_len - 1);
        for (int k = 0; k < batch_len; k++)
        begin
            exp_word.sorted_value  = batch_words[k];
            exp_word.run_end       = (k + 1 == batch_len);
            exp_word.compare_count = compare_total[COUNT_W-1:0];
            exp_word.move_count    = move_total[COUNT_W-1:0];
            exp_word.overflowed    = batch_overflow;
            sorted_expect.push_back(exp_word);
        end
        batch_len = 0;
        batch_overflow = 1'b0;
    endfunction

    function automatic void add_word(input bit signed [MSC_VALUE_WIDTH-1:0] value,
                                     input bit last, input bit drain_first);
        input_word_t w;
        w.value = value;
        w.final_item = last;
        w.hold_for_drain = drain_first;
        pending_words.push_back(w);
        words_queued++;
    endfunction

    function automatic bit signed [MSC_VALUE_WIDTH-1:0] pick_value();
        int unsigned r;
        bit signed [MSC_VALUE_WIDTH-1:0] v;
        r = $urandom_range(0, 9);
        if (r < 5)
            v = $urandom;
        else if (r < 8)
            v = $signed($urandom_range(0, 8)) - 4;  // small spread gives many ties
        else if (r == 8)
            v = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
        else
            v = $urandom_range(0, 1) ? 32'sh7fffffff - $urandom_range(0, 3)
                                     : 32'sh80000000 + $urandom_range(0, 3);
        return v;
    endfunction

    function automatic void add_batch(input int unsigned len, input bit drain_first);
        for (int unsigned i = 0; i < len; i++)
            add_word(pick_value(), i + 1 == len, drain_first && i == 0);
    endfunction

    function automatic void report_field(input string field, input longint exp_val,
                                         input longint got_val);
        if (exp_val != got_val)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, exp_val, got_val);
        end
    endfunction

    // input side: accepted words feed the predictor
    always @(posedge clk)
    begin
        if (rst_n && items.valid && items.ready)
        begin
            word_taken = 1'b1;
            words_accepted++;
            if (batch_len < MSC_MAX_ITEMS)
            begin
                batch_words[batch_len] = items.value;
                batch_len++;
            end
            else
            begin
                batch_overflow = 1'b1;
            end
            if (items.final_item)
                predict_sorted_run();
        end
    end

    // result side: compare with the oldest expected word
    always @(posedge clk)
    begin
        sorted_word_t exp_word;
        if (rst_n && results.valid && results.ready)
        begin
            results_seen++;
            if (sorted_expect.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected result word, expected none, actual %0d",
                         $time, results.sorted_value);
            end
            else
            begin
                exp_word = sorted_expect.pop_front();
                report_field("sorted_value", exp_word.sorted_value, results.sorted_value);
                report_field("run_end", exp_word.run_end, results.run_end);
                report_field("compare_count", exp_word.compare_count, results.compare_count);
                report_field("move_count", exp_word.move_count, results.move_count);
                report_field("overflowed", exp_word.overflowed, results.overflowed);
            end
        end
    end

    // sender: bursts of words with random gaps
    always @(negedge clk)
    begin
        input_word_t next_word;
        if (rst_n && (!items.valid || word_taken))
        begin
            word_taken = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
                items.valid <= 1'b0;
            end
            else if (pending_words.size() > 0 &&
                     !(pending_words[0].hold_for_drain && sorted_expect.size() != 0))
            begin
                next_word = pending_words.pop_front();
                items.valid      <= 1'b1;
                items.value      <= next_word.value;
                items.final_item <= next_word.final_item;
                if (burst_left <= 1)
                begin
                    burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
                    gap_left = $urandom_range(0, 6);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                items.valid <= 1'b0;
            end
        end
    end

    // receiver: stall mode changes every 40 results, plus one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
            if (stall_left > 0)
            begin
                stall_left--;
                results.ready <= 1'b0;
            end
            else if (!long_hold_done && results_seen >= 150 && results.valid)
            begin
                long_hold_done = 1'b1;
                stall_left = 399;
                results.ready <= 1'b0;
            end
            else
            begin
                case ((results_seen / 40) % 3)
                    0:       results.ready <= 1'b1;
                    1:       results.ready <= ($urandom_range(0, 9) < 6);
                    default: results.ready <= stall_pattern[0];
                endcase
            end
        end
    end

    initial
    begin
        int unsigned len;
        int unsigned r;
        rst_n = 1'b0;
        items.valid = 1'b0;
        items.value = '0;
        items.final_item = 1'b0;
        results.ready = 1'b0;
        stall_pattern = 8'b1011_0011;
        burst_left = 5;

        // directed: single words at the extremes
        add_word(32'sh7fffffff, 1'b1, 1'b0);
        add_word(32'sh80000000, 1'b1, 1'b0);
        // mixed extremes
        add_word(0, 1'b0, 1'b0);
        add_word(-1, 1'b0, 1'b0);
        add_word(32'sh7fffffff, 1'b0, 1'b0);
        add_word(32'sh80000000, 1'b0, 1'b0);
        add_word(1, 1'b1, 1'b0);
        // ties
        add_word(5, 1'b0, 1'b0);
        add_word(5, 1'b0, 1'b0);
        add_word(-5, 1'b0, 1'b0);
        add_word(5, 1'b0, 1'b0);
        add_word(-5, 1'b1, 1'b0);
        // already ascending, then descending
        for (int i = 1; i <= 4; i++)
            add_word(i, i == 4, 1'b0);
        for (int i = 4; i >= 1; i--)
            add_word(i, i == 1, 1'b0);
        add_word(3, 1'b0, 1'b1);
        add_word(-3, 1'b1, 1'b0);

        // random: one overflowing batch whose final word is dropped, one full batch
        add_batch(66, 1'b1);
        add_batch(MSC_MAX_ITEMS, 1'b0);
        while (words_queued < 470)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                len = $urandom_range(1, 12);
            else if (r < 90)
                len = $urandom_range(13, 63);
            else if (r < 95)
                len = MSC_MAX_ITEMS;
            else
                len = $urandom_range(65, 70);
            add_batch(len, $urandom_range(0, 5) == 0);
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (words_accepted < words_queued)
            @(posedge clk);
        while (sorted_expect.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
